// ----- sv/bsc_pkg.sv -----
// Package with shared types and constants for the barometric compensation block.
`default_nettype none
package bsc_pkg;
  localparam int RawW = 20;
  localparam int CalW = 48;
  localparam int CfgIdxW = 2;
  localparam int TempW = 16;
  localparam int PresW = 25;
  localparam logic [CfgIdxW-1:0] CfgCalTemp = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCalPresA = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCalPresB = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCalPresC = 2'd3;
  localparam logic [63:0] PresMax = 64'h1FF_FFFF;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_centi;
    logic [PresW-1:0] pressure_q24_8;
    logic pressure_invalid;
  } bsc_out_t;
endpackage
`default_nettype wire

// ----- sv/bsc_stream_if.sv -----
// Valid/ready channel interface carrying one payload transaction.
`default_nettype none
interface bsc_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/bsc_divider.sv -----
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
`default_nettype none
module bsc_divider #(
  parameter int SideW = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  input  wire logic [SideW-1:0] side_in,
  output logic [63:0] quotient,
  output logic [SideW-1:0] side_out
);
  import bsc_pkg::*;
  localparam int N = 64;
  logic [63:0] rem [N+1];
  logic [63:0] quo [N+1];
  logic [63:0] dsr [N+1];
  logic neg [N+1];
  logic [SideW-1:0] side [N+1];
  logic [63:0] ma;
  logic [63:0] mb;

  always_comb begin
    ma = dividend[63] ? 64'(0 - dividend) : dividend;
    mb = divisor[63] ? 64'(0 - divisor) : divisor;
  end

  assign rem[0] = '0;
  assign quo[0] = ma;
  assign dsr[0] = mb;
  assign neg[0] = dividend[63] ^ divisor[63];
  assign side[0] = side_in;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [64:0] trial;
    logic [63:0] rsh;
    always_comb begin
      rsh = {rem[i][62:0], quo[i][63]};
      trial = {1'b0, rsh} - {1'b0, dsr[i]};
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        rem[i+1] <= trial[64] ? rsh : trial[63:0];
        quo[i+1] <= {quo[i][62:0], ~trial[64]};
        dsr[i+1] <= dsr[i];
        neg[i+1] <= neg[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign quotient = neg[N] ? 64'(0 - quo[N]) : quo[N];
  assign side_out = side[N];
  logic unused;
  assign unused = rst;
endmodule
`default_nettype wire

// ----- sv/baro_sensor_compensation.sv -----
// Top level of the barometric temperature and pressure compensation pipeline.
// Throughput: one transaction per cycle while the output is not stalled.
// The 64-stage divider pipeline accounts for most of the depth.
// The whole pipeline advances together and holds while the output is stalled.
// Reset (synchronous) clears calibration registers and all valid bits.
`default_nettype none
module baro_sensor_compensation (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [bsc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bsc_pkg::CalW-1:0] cfg_data,
  bsc_stream_if.sink in_ch,
  bsc_stream_if.source out_ch
);
  import bsc_pkg::*;
  localparam int Depth = 81;

  logic [CalW-1:0] cal [4];
  logic [Depth-1:0] vld;
  logic advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) cal[i] <= '0;
    end else if (cfg_we) begin
      cal[cfg_index] <= cfg_data;
    end
  end

  assign advance = !vld[Depth-1] || out_ch.ready;
  assign in_ch.ready = advance;
  assign out_ch.valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (advance) vld <= {vld[Depth-2:0], in_ch.valid};
  end

  // Calibration words.
  logic [31:0] t1, t2, t3;
  logic [15:0] p1, p2, p3, p5, p6, p8, p9;
  logic [63:0] p4, p7;
  always_comb begin
    t1 = {16'd0, cal[CfgCalTemp][15:0]};
    t2 = 32'(signed'(cal[CfgCalTemp][31:16]));
    t3 = 32'(signed'(cal[CfgCalTemp][47:32]));
    p1 = cal[CfgCalPresA][15:0];
    p2 = cal[CfgCalPresA][31:16];
    p3 = cal[CfgCalPresA][47:32];
    p4 = 64'(signed'(cal[CfgCalPresB][15:0]));
    p5 = cal[CfgCalPresB][31:16];
    p6 = cal[CfgCalPresB][47:32];
    p7 = 64'(signed'(cal[CfgCalPresC][15:0]));
    p8 = cal[CfgCalPresC][31:16];
    p9 = cal[CfgCalPresC][47:32];
  end

  // Stage 1: temperature differences.
  logic [31:0] s1_a, s1_d;
  logic [RawW-1:0] s1_rp;
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_a <= 32'(in_ch.data.raw_temperature >> 3) - (t1 << 1);
      s1_d <= 32'(in_ch.data.raw_temperature >> 4) - t1;
      s1_rp <= in_ch.data.raw_pressure;
    end
  end

  // Stage 2: first products.
  logic [31:0] s2_v1, s2_dd;
  logic [RawW-1:0] s2_rp;
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_v1 <= 32'($signed(s1_a * t2) >>> 11);
      s2_dd <= 32'($signed(s1_d * s1_d) >>> 12);
      s2_rp <= s1_rp;
    end
  end

  // Stage 3: t_fine.
  logic [31:0] s3_tf;
  logic [RawW-1:0] s3_rp;
  always_ff @(posedge clk) begin
    if (advance) begin
      s3_tf <= s2_v1 + 32'($signed(s2_dd * t3) >>> 14);
      s3_rp <= s2_rp;
    end
  end

  // Stage 4: temperature result and w1 base.
  logic [31:0] t_raw;
  logic [TempW-1:0] t_sat;
  always_comb begin
    t_raw = 32'($signed(s3_tf * 32'd5 + 32'd128) >>> 8);
    if ($signed(t_raw) < -32768) t_sat = 16'h8000;
    else if ($signed(t_raw) > 32767) t_sat = 16'h7FFF;
    else t_sat = t_raw[15:0];
  end
  logic [32:0] s4_w;
  logic [TempW-1:0] s4_t;
  logic [RawW-1:0] s4_rp;
  always_ff @(posedge clk) begin
    if (advance) begin
      s4_w <= 33'(signed'(s3_tf)) - 33'd128000;
      s4_t <= t_sat;
      s4_rp <= s3_rp;
    end
  end

  // Stage 5: square and linear terms (w fits in 33 bits).
  logic [63:0] s5_ww, s5_w5, s5_w2;
  logic [TempW-1:0] s5_t;
  logic [RawW-1:0] s5_rp;
  always_ff @(posedge clk) begin
    if (advance) begin
      s5_ww <= 64'($signed(s4_w) * $signed(s4_w));
      s5_w5 <= 64'($signed(s4_w) * $signed(p5));
      s5_w2 <= 64'($signed(s4_w) * $signed(p2));
      s5_t <= s4_t;
      s5_rp <= s4_rp;
    end
  end

  // Stage 6: products with the calibration words.
  logic [63:0] s6_x6, s6_x3, s6_w5, s6_w2;
  logic [TempW-1:0] s6_t;
  logic [RawW-1:0] s6_rp;
  always_ff @(posedge clk) begin
    if (advance) begin
      s6_x6 <= 64'($signed(s5_ww) * $signed(p6));
      s6_x3 <= 64'($signed(s5_ww) * $signed(p3));
      s6_w5 <= s5_w5;
      s6_w2 <= s5_w2;
      s6_t <= s5_t;
      s6_rp <= s5_rp;
    end
  end

  // Stage 7: w2 and pre-w1.
  logic [63:0] s7_w2, s7_v;
  logic [TempW-1:0] s7_t;
  logic [RawW-1:0] s7_rp;
  always_ff @(posedge clk) begin
    if (advance) begin
      s7_w2 <= s6_x6 + (s6_w5 << 17) + (p4 << 35);
      s7_v <= (64'd1 << 47) + 64'($signed(s6_x3) >>> 8) + (s6_w2 << 12);
      s7_t <= s6_t;
      s7_rp <= s6_rp;
    end
  end

  // Stage 8: w1 product.
  logic [63:0] s8_m, s8_w2;
  logic [TempW-1:0] s8_t;
  logic [RawW-1:0] s8_rp;
  always_ff @(posedge clk) begin
    if (advance) begin
      s8_m <= 64'(s7_v * p1);
      s8_w2 <= s7_w2;
      s8_t <= s7_t;
      s8_rp <= s7_rp;
    end
  end

  // Stage 9: w1 and the numerator base.
  logic [63:0] s9_w1, s9_n;
  logic [TempW-1:0] s9_t;
  always_ff @(posedge clk) begin
    if (advance) begin
      s9_w1 <= 64'($signed(s8_m) >>> 33);
      s9_n <= ((64'd1048576 - 64'(s8_rp)) << 31) - s8_w2;
      s9_t <= s8_t;
    end
  end

  // Stage 10: numerator times 3125.
  logic [63:0] s10_n, s10_w1;
  logic [TempW-1:0] s10_t;
  always_ff @(posedge clk) begin
    if (advance) begin
      s10_n <= s9_n * 64'd3125;
      s10_w1 <= s9_w1;
      s10_t <= s9_t;
    end
  end

  // Stages 11 to 12: hold registers before the divider.
  logic [63:0] s11_n, s11_w1, s12_n, s12_w1;
  logic [TempW-1:0] s11_t, s12_t;
  always_ff @(posedge clk) begin
    if (advance) begin
      s11_n <= s10_n;
      s11_w1 <= s10_w1;
      s11_t <= s10_t;
      s12_n <= s11_n;
      s12_w1 <= s11_w1;
      s12_t <= s11_t;
    end
  end

  logic [63:0] dq;
  logic [TempW:0] dside;
  logic dzero;
  assign dzero = (s12_w1 == '0);
  bsc_divider #(.SideW(TempW + 1)) u_div (
    .clk(clk), .rst(rst), .advance(advance),
    .dividend(s12_n), .divisor(dzero ? 64'd1 : s12_w1),
    .side_in({dzero, s12_t}), .quotient(dq), .side_out(dside)
  );

  // Stage 77: register quotient.
  logic [63:0] q_p, q_ps;
  logic [TempW:0] q_side;
  always_ff @(posedge clk) begin
    if (advance) begin
      q_p <= dq;
      q_ps <= 64'($signed(dq) >>> 13);
      q_side <= dside;
    end
  end

  // Stage 78: first correction products.
  logic [63:0] r_a, r_b, r_ps, r_p;
  logic [TempW:0] r_side;
  always_ff @(posedge clk) begin
    if (advance) begin
      r_a <= 64'($signed(q_ps) * $signed(p9));
      r_b <= 64'(($signed(q_p) * $signed(p8)) >>> 19);
      r_ps <= q_ps;
      r_p <= q_p;
      r_side <= q_side;
    end
  end

  // Stage 79: 32-bit partial products of the second correction product.
  logic [63:0] u_ll, u_x2, u_p;
  logic [31:0] u_lh, u_hl;
  logic [TempW:0] u_side;
  always_ff @(posedge clk) begin
    if (advance) begin
      u_ll <= 64'(r_a[31:0] * r_ps[31:0]);
      u_lh <= 32'(r_a[31:0] * r_ps[63:32]);
      u_hl <= 32'(r_a[63:32] * r_ps[31:0]);
      u_x2 <= r_b;
      u_p <= r_p;
      u_side <= r_side;
    end
  end

  // Stage 80: second correction term.
  logic [63:0] v_x1, v_x2, v_p;
  logic [TempW:0] v_side;
  always_ff @(posedge clk) begin
    if (advance) begin
      v_x1 <= 64'($signed(u_ll + {u_lh + u_hl, 32'd0}) >>> 25);
      v_x2 <= u_x2;
      v_p <= u_p;
      v_side <= u_side;
    end
  end

  // Stage 81: final sum and saturation.
  logic [63:0] pf;
  logic [PresW-1:0] psat;
  always_comb begin
    pf = 64'($signed(v_p + v_x1 + v_x2) >>> 8) + (p7 << 4);
    if (v_side[TempW] || pf[63]) psat = '0;
    else if (pf > PresMax) psat = PresMax[PresW-1:0];
    else psat = pf[PresW-1:0];
  end
  bsc_out_t res;
  always_ff @(posedge clk) begin
    if (advance) begin
      res.temperature_centi <= v_side[TempW-1:0];
      res.pressure_q24_8 <= psat;
      res.pressure_invalid <= v_side[TempW];
    end
  end
  assign out_ch.data = res;
endmodule
`default_nettype wire
